>>> sv/aws_pkg.sv
// Shared types, codes and constants of the accelerometer window statistics block.
package aws_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 64;

  localparam int unsigned AXIS_W      = 16;
  localparam int unsigned MAG_W       = 24;
  localparam int unsigned SQ_W        = 32;
  localparam int unsigned RES_W       = 21;
  localparam int unsigned WNUM_W      = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned SENS_W      = 15;
  localparam int unsigned LEN_CFG_W   = 7;
  localparam int unsigned CFG_W       = 15;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 120;

  localparam logic [CFG_IDX_W-1:0] CFG_SENS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 1'b1;

  localparam logic [SENS_W-1:0]    SENS_RESET = 15'd4096;
  localparam logic [LEN_CFG_W-1:0] LEN_RESET  = 7'd32;

  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PARTIAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_Z,
    OP_SQ_SUM,
    OP_SQRT_MAG,
    OP_MAG_SQ,
    OP_ACC,
    OP_DEN,
    OP_DIV_AXIS,
    OP_SAVE_AXIS,
    OP_VAR_MUL,
    OP_DIV_V,
    OP_SQRT_V,
    OP_DIV_S,
    OP_SAVE_S,
    OP_ZERO_S,
    OP_EMIT
  } aws_op_e;

  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_Z,
    SEL_MAG
  } aws_sel_e;

  typedef struct packed {
    aws_op_e  op;
    aws_sel_e sel;
  } aws_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic close;
    logic discard;
    logic multi;
  } aws_stat_t;

endpackage

>>> sv/aws_div.sv
// Restoring divider that produces one quotient bit per cycle.
module aws_div import aws_pkg::*; #(
  parameter int unsigned NumW = 62,
  parameter int unsigned DenW = 22,
  localparam int unsigned CntW = $clog2(NumW + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [DenW:0]   rem_sh;
  logic [DenW:0]   rem_sub;
  logic            ge;

  assign rem_sh  = {rem_q, num_q[NumW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(NumW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CntW'(1);
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
      num_q <= {num_q[NumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

>>> sv/aws_sqrt.sv
// Integer square root that settles one root bit per cycle from the top.
module aws_sqrt import aws_pkg::*; #(
  parameter int unsigned InW = 62,
  localparam int unsigned RootW = InW / 2,
  localparam int unsigned IterW = $clog2(RootW + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [InW-1:0]   val_i,
  input  logic [IterW-1:0] iters_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  logic [InW-1:0]   val_q;
  logic [RootW:0]   rem_q;
  logic [RootW-1:0] root_q;
  logic [IterW-1:0] cnt_q;
  logic             done_q;
  logic [RootW+2:0] rem_sh;
  logic [RootW+2:0] trial;
  logic [RootW+2:0] rem_sub;
  logic             ge;

  // The value is left aligned, so each step takes the next two bits from the top.
  assign rem_sh  = {rem_q, val_q[InW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= iters_i;
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - IterW'(1);
      done_q <= (cnt_q == IterW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      val_q  <= {val_q[InW-3:0], 2'b00};
      rem_q  <= ge ? rem_sub[RootW:0] : rem_sh[RootW:0];
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> sv/aws_dpath.sv
// Datapath: sample registers, running sums, configuration, arithmetic units and result register.
module aws_dpath import aws_pkg::*; #(
  parameter int unsigned MaxWindow = MAX_WINDOW_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic                   in_last_i,
  input  aws_cmd_t               cmd_i,
  output aws_stat_t              st_o,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic [KIND_W-1:0]      out_kind_o
);

  localparam int unsigned CntW  = $clog2(MaxWindow + 1);
  localparam int unsigned SumAW = AXIS_W + CntW;
  localparam int unsigned SumMW = MAG_W + CntW;
  localparam int unsigned QW    = 2 * MAG_W + CntW;
  localparam int unsigned DW    = 2 * MAG_W + 2 * CntW;
  localparam int unsigned RootW = DW / 2;
  localparam int unsigned IterW = $clog2(RootW + 1);
  localparam int unsigned DenW  = (CntW + SENS_W > 2 * CntW) ? CntW + SENS_W : 2 * CntW;
  localparam int unsigned LenW  = (CntW > LEN_CFG_W) ? CntW : LEN_CFG_W;
  localparam int unsigned FracAxis = 16;
  localparam int unsigned FracMag  = 8;
  localparam int unsigned PadW  = OUT_TDATA_W - WNUM_W - 5 * RES_W;
  localparam logic [DW-1:0] QPosMax = DW'(1048575);
  localparam logic [DW-1:0] QNegMax = DW'(1048576);
  localparam logic [DW-1:0] QUMax   = DW'(2097151);
  localparam logic [RES_W-1:0] ResSMax = 21'h0FFFFF;
  localparam logic [RES_W-1:0] ResSMin = 21'h100000;
  localparam logic [WNUM_W-1:0] WnumMax = 8'hFF;

  // Configuration.
  logic [SENS_W-1:0]    sens_q;
  logic [LEN_CFG_W-1:0] len_cfg_q;
  logic [SENS_W-1:0]    sens_eff;
  logic [LenW-1:0]      len_eff;

  // Window state.
  logic signed [SumAW-1:0] sum_x_q, sum_y_q, sum_z_q;
  logic [SumMW-1:0]        sum_m_q;
  logic [QW-1:0]           sum_q2_q;
  logic [CntW-1:0]         fill_q;
  logic [WNUM_W-1:0]       wcnt_q;

  // Working registers.
  logic signed [AXIS_W-1:0] x_q, y_q, z_q;
  logic                     last_q;
  logic [SQ_W-1:0]          mul_q, sq_q;
  logic [2*MAG_W-1:0]       msq_q;
  logic [DenW-1:0]          den_q, den2_q;
  logic [DW-1:0]            nq_q, ss_q;
  logic [RES_W-1:0]         mean_q [4];
  logic [RES_W-1:0]         std_q;

  // Result register.
  logic [WNUM_W-1:0] o_wnum_q;
  logic [RES_W-1:0]  o_x_q, o_y_q, o_z_q, o_m_q, o_s_q;
  logic [KIND_W-1:0] o_kind_q;

  logic signed [AXIS_W-1:0] sq_sel;
  logic signed [SQ_W-1:0]   sq_term;
  logic                     div_start, div_done, sqrt_start, sqrt_done;
  logic [DW-1:0]            div_num, div_quo, sqrt_val;
  logic [DenW-1:0]          div_den;
  logic [IterW-1:0]         sqrt_iters;
  logic [RootW-1:0]         sqrt_root;
  logic [MAG_W-1:0]         mag;
  logic signed [SumAW-1:0]  axis_sum;
  logic                     axis_neg;
  logic [SumAW-1:0]         axis_abs;
  logic [DW-1:0]            neg_quo;
  logic [RES_W-1:0]         axis_sat;
  logic                     full, close, discard;
  logic [KIND_W-1:0]        kind;
  logic [DW-1:0]            nq_prod, ss_prod;
  logic [DenW-1:0]          den_prod, den2_prod;
  logic [2*MAG_W-1:0]       msq_prod;

  assign sens_eff = (sens_q == '0) ? SENS_W'(1) : sens_q;

  always_comb begin
    if (len_cfg_q == '0) begin
      len_eff = LenW'(1);
    end else if (LenW'(len_cfg_q) > LenW'(MaxWindow)) begin
      len_eff = LenW'(MaxWindow);
    end else begin
      len_eff = LenW'(len_cfg_q);
    end
  end

  assign full    = LenW'(fill_q) >= len_eff;
  assign close   = full || last_q;
  assign discard = !full && last_q && (LenW'(fill_q) < (len_eff >> 2));
  assign kind    = full ? KIND_FULL : (discard ? KIND_DISCARD : KIND_PARTIAL);

  assign st_o.sqrt_done = sqrt_done;
  assign st_o.div_done  = div_done;
  assign st_o.close     = close;
  assign st_o.discard   = discard;
  assign st_o.multi     = fill_q > CntW'(1);

  // Squares of the axes share one multiplier.
  always_comb begin
    case (cmd_i.op)
      OP_SQ_Y: sq_sel = y_q;
      OP_SQ_Z: sq_sel = z_q;
      default: sq_sel = x_q;
    endcase
  end
  assign sq_term = sq_sel * sq_sel;

  assign mag       = sqrt_root[MAG_W-1:0];
  assign msq_prod  = mag * mag;
  assign den_prod  = DenW'(fill_q) * DenW'(sens_eff);
  assign nq_prod   = fill_q * sum_q2_q;
  assign ss_prod   = sum_m_q * sum_m_q;
  assign den2_prod = DenW'(fill_q) * DenW'(CntW'(fill_q - CntW'(1)));

  always_comb begin
    case (cmd_i.sel)
      SEL_X:   axis_sum = sum_x_q;
      SEL_Y:   axis_sum = sum_y_q;
      default: axis_sum = sum_z_q;
    endcase
  end
  assign axis_neg = (cmd_i.sel != SEL_MAG) && axis_sum[SumAW-1];
  assign axis_abs = axis_neg ? SumAW'(-axis_sum) : SumAW'(axis_sum);
  assign neg_quo  = DW'(0) - div_quo;

  always_comb begin
    if (cmd_i.sel == SEL_MAG) begin
      axis_sat = (div_quo > QUMax) ? '1 : div_quo[RES_W-1:0];
    end else if (axis_neg) begin
      axis_sat = (div_quo > QNegMax) ? ResSMin : neg_quo[RES_W-1:0];
    end else begin
      axis_sat = (div_quo > QPosMax) ? ResSMax : div_quo[RES_W-1:0];
    end
  end

  always_comb begin
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = den_q;
    sqrt_start = 1'b0;
    sqrt_val   = {sq_q, {(DW - SQ_W){1'b0}}};
    sqrt_iters = IterW'(MAG_W);
    case (cmd_i.op)
      OP_DIV_AXIS: begin
        div_start = 1'b1;
        if (cmd_i.sel == SEL_MAG) begin
          div_num = (DW'(sum_m_q) << FracMag) + DW'(den_q >> 1);
        end else begin
          div_num = (DW'(axis_abs) << FracAxis) + DW'(den_q >> 1);
        end
      end
      OP_DIV_V: begin
        div_start = 1'b1;
        div_num   = nq_q - ss_q;
        div_den   = den2_q;
      end
      OP_DIV_S: begin
        div_start = 1'b1;
        div_num   = (DW'(sqrt_root) << FracMag) + DW'(sens_eff >> 1);
        div_den   = DenW'(sens_eff);
      end
      OP_SQRT_MAG: sqrt_start = 1'b1;
      OP_SQRT_V: begin
        sqrt_start = 1'b1;
        sqrt_val   = div_quo;
        sqrt_iters = IterW'(RootW);
      end
      default: ;
    endcase
  end

  aws_div #(.NumW(DW), .DenW(DenW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  aws_sqrt #(.InW(DW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sqrt_val),
    .iters_i (sqrt_iters),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // Configuration and window state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q    <= SENS_RESET;
      len_cfg_q <= LEN_RESET;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      sum_z_q   <= '0;
      sum_m_q   <= '0;
      sum_q2_q  <= '0;
      fill_q    <= '0;
      wcnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SENS: sens_q    <= cfg_wdata_i[SENS_W-1:0];
          CFG_LEN:  len_cfg_q <= cfg_wdata_i[LEN_CFG_W-1:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_ACC: begin
          sum_x_q  <= sum_x_q + SumAW'(x_q);
          sum_y_q  <= sum_y_q + SumAW'(y_q);
          sum_z_q  <= sum_z_q + SumAW'(z_q);
          sum_m_q  <= sum_m_q + SumMW'(mag);
          sum_q2_q <= sum_q2_q + QW'(msq_q);
          fill_q   <= fill_q + CntW'(1);
        end
        OP_EMIT: begin
          sum_x_q  <= '0;
          sum_y_q  <= '0;
          sum_z_q  <= '0;
          sum_m_q  <= '0;
          sum_q2_q <= '0;
          fill_q   <= '0;
          if (last_q) begin
            wcnt_q <= '0;
          end else if (wcnt_q != WnumMax) begin
            wcnt_q <= wcnt_q + WNUM_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        x_q    <= in_data_i[AXIS_W-1:0];
        y_q    <= in_data_i[2*AXIS_W-1:AXIS_W];
        z_q    <= in_data_i[3*AXIS_W-1:2*AXIS_W];
        last_q <= in_last_i;
      end
      OP_SQ_X: mul_q <= SQ_W'(sq_term);
      OP_SQ_Y: begin
        mul_q <= SQ_W'(sq_term);
        sq_q  <= mul_q;
      end
      OP_SQ_Z: begin
        mul_q <= SQ_W'(sq_term);
        sq_q  <= sq_q + mul_q;
      end
      OP_SQ_SUM:    sq_q <= sq_q + mul_q;
      OP_MAG_SQ:    msq_q <= msq_prod;
      OP_DEN:       den_q <= den_prod;
      OP_SAVE_AXIS: mean_q[cmd_i.sel] <= axis_sat;
      OP_VAR_MUL: begin
        nq_q   <= nq_prod;
        ss_q   <= ss_prod;
        den2_q <= den2_prod;
      end
      OP_SAVE_S: std_q <= (div_quo > QUMax) ? '1 : div_quo[RES_W-1:0];
      OP_ZERO_S: std_q <= '0;
      OP_EMIT: begin
        o_wnum_q <= wcnt_q;
        o_kind_q <= kind;
        if (discard) begin
          o_x_q <= '0;
          o_y_q <= '0;
          o_z_q <= '0;
          o_m_q <= '0;
          o_s_q <= '0;
        end else begin
          o_x_q <= mean_q[SEL_X];
          o_y_q <= mean_q[SEL_Y];
          o_z_q <= mean_q[SEL_Z];
          o_m_q <= mean_q[SEL_MAG];
          o_s_q <= std_q;
        end
      end
      default: ;
    endcase
  end

  assign out_data_o = {{PadW{1'b0}}, o_s_q, o_m_q, o_z_q, o_y_q, o_x_q, o_wnum_q};
  assign out_kind_o = o_kind_q;

endmodule

>>> sv/aws_ctrl.sv
// Controller state machine that sequences the datapath for each sample and window close.
module aws_ctrl import aws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output aws_cmd_t  cmd_o,
  input  aws_stat_t st_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_Z, S_SQ_SUM, S_SQRT_M, S_WAIT_M, S_MAG_SQ,
    S_ACC, S_DECIDE, S_DEN, S_DIV, S_DIV_WAIT, S_SAVE, S_VAR_MUL, S_DIV_V,
    S_WAIT_V, S_SQRT_V, S_WAIT_SV, S_DIV_S, S_WAIT_S, S_SAVE_S, S_ZERO_S, S_EMIT
  } state_e;

  state_e   state_q;
  aws_sel_e sel_q;
  logic     out_valid_q;
  logic     out_valid_d;
  logic     out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op  = OP_NONE;
    cmd_o.sel = sel_q;
    case (state_q)
      S_IDLE:    if (in_valid_i) cmd_o.op = OP_LATCH;
      S_SQ_X:    cmd_o.op = OP_SQ_X;
      S_SQ_Y:    cmd_o.op = OP_SQ_Y;
      S_SQ_Z:    cmd_o.op = OP_SQ_Z;
      S_SQ_SUM:  cmd_o.op = OP_SQ_SUM;
      S_SQRT_M:  cmd_o.op = OP_SQRT_MAG;
      S_MAG_SQ:  cmd_o.op = OP_MAG_SQ;
      S_ACC:     cmd_o.op = OP_ACC;
      S_DEN:     cmd_o.op = OP_DEN;
      S_DIV:     cmd_o.op = OP_DIV_AXIS;
      S_SAVE:    cmd_o.op = OP_SAVE_AXIS;
      S_VAR_MUL: cmd_o.op = OP_VAR_MUL;
      S_DIV_V:   cmd_o.op = OP_DIV_V;
      S_SQRT_V:  cmd_o.op = OP_SQRT_V;
      S_DIV_S:   cmd_o.op = OP_DIV_S;
      S_SAVE_S:  cmd_o.op = OP_SAVE_S;
      S_ZERO_S:  cmd_o.op = OP_ZERO_S;
      S_EMIT:    if (out_free) cmd_o.op = OP_EMIT;
      default: ;
    endcase
  end

  // A taken result clears the valid flag, a newly loaded one sets it again.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.op == OP_EMIT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= SEL_X;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE:     if (in_valid_i) state_q <= S_SQ_X;
        S_SQ_X:     state_q <= S_SQ_Y;
        S_SQ_Y:     state_q <= S_SQ_Z;
        S_SQ_Z:     state_q <= S_SQ_SUM;
        S_SQ_SUM:   state_q <= S_SQRT_M;
        S_SQRT_M:   state_q <= S_WAIT_M;
        S_WAIT_M:   if (st_i.sqrt_done) state_q <= S_MAG_SQ;
        S_MAG_SQ:   state_q <= S_ACC;
        S_ACC:      state_q <= S_DECIDE;
        S_DECIDE: begin
          if (!st_i.close) begin
            state_q <= S_IDLE;
          end else if (st_i.discard) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_DEN;
          end
        end
        S_DEN: begin
          sel_q   <= SEL_X;
          state_q <= S_DIV;
        end
        S_DIV:      state_q <= S_DIV_WAIT;
        S_DIV_WAIT: if (st_i.div_done) state_q <= S_SAVE;
        S_SAVE: begin
          if (sel_q == SEL_MAG) begin
            state_q <= st_i.multi ? S_VAR_MUL : S_ZERO_S;
          end else begin
            sel_q   <= aws_sel_e'(2'(sel_q + 2'd1));
            state_q <= S_DIV;
          end
        end
        S_VAR_MUL:  state_q <= S_DIV_V;
        S_DIV_V:    state_q <= S_WAIT_V;
        S_WAIT_V:   if (st_i.div_done) state_q <= S_SQRT_V;
        S_SQRT_V:   state_q <= S_WAIT_SV;
        S_WAIT_SV:  if (st_i.sqrt_done) state_q <= S_DIV_S;
        S_DIV_S:    state_q <= S_WAIT_S;
        S_WAIT_S:   if (st_i.div_done) state_q <= S_SAVE_S;
        S_SAVE_S:   state_q <= S_EMIT;
        S_ZERO_S:   state_q <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default:    state_q <= S_IDLE;
      endcase
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT) |-> (!out_valid_q || out_ready_i))
    else $error("result loaded while the previous one is still waiting");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_i.div_done |-> (state_q == S_DIV_WAIT || state_q == S_WAIT_V || state_q == S_WAIT_S))
    else $error("divider finished outside a divide wait state");

  a_sqrt_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_i.sqrt_done |-> (state_q == S_WAIT_M || state_q == S_WAIT_SV))
    else $error("square root finished outside a root wait state");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT) |=> out_valid_q)
    else $error("loaded result not shown as valid");

endmodule

>>> sv/accel_window_statistics_top.sv
// Top level of the accelerometer window statistics block.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+----------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | tdata x,y,z samples; tlast burst end
//  m_axis   | out       | m_axis_tvalid/tready   | tdata window stats; tuser window kind
//  cfg      | in        | cfg_we_i               | cfg_index_i register, cfg_wdata_i value
//
// A sample request runs from acceptance to the next ready through squaring in S_SQ_X,
// S_SQ_Y, S_SQ_Z and S_SQ_SUM on one shared multiplier, the bit-serial square root, and
// the states that accumulate and decide. A window close adds work in the shared
// one-bit-per-cycle divider (up to six divisions) and the square root; a discarded partial
// window skips these and goes straight to the result. Reset clears sums and counters and
// returns the configuration to its reset values at once.
// A finished result waits in an output register while the next samples are accepted;
// only a further window close stalls until that result has been taken.
module accel_window_statistics_top import aws_pkg::*; #(
  parameter int unsigned MaxWindow = MAX_WINDOW_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port: index 0 sensitivity, index 1 window length.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  // Sample stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata from bit 0: accel_x[15:0], accel_y[31:16], accel_z[47:32].
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata from bit 0: window_number[7:0], mean_x_g[28:8], mean_y_g[49:29],
  // mean_z_g[70:50], mean_magnitude_g[91:71], std_magnitude_g[112:92], zero pad.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser from bit 0: window_kind[1:0].
  output logic [KIND_W-1:0]      m_axis_tuser
);

  // The controller and the datapath talk only through these two bundles.
  aws_cmd_t  cmd;
  aws_stat_t st;

  aws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  // The datapath keeps the running sums, including the sum of squared magnitudes, so
  // the variance needs no walk over stored samples at window close.
  aws_dpath #(.MaxWindow(MaxWindow)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser)
  );

endmodule

>>> sim/window_stats_checker.sv
// Checker that predicts and compares the window statistics of the block.
module window_stats_checker import aws_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [KIND_W-1:0]      m_axis_tuser,
  output int                     errors_o,
  output int                     pending_o,
  output int                     checked_o
);

  typedef struct {
    logic [WNUM_W-1:0] wnum;
    logic [RES_W-1:0]  mx, my, mz, mmag, smag;
    logic [KIND_W-1:0] kind;
  } window_stats_t;

  window_stats_t          stats_q[$];
  logic [SENS_W-1:0]      sens_reg;
  logic [LEN_CFG_W-1:0]   len_reg;
  longint                 acc_x, acc_y, acc_z;
  longint unsigned        acc_mag;
  logic [MAG_W-1:0]       mag_mem[MAX_WINDOW_DEF];
  int unsigned            fill;
  int unsigned            wcount;

  assign pending_o = stats_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  function automatic logic [RES_W-1:0] sat_unsigned(longint unsigned v);
    return (v > 64'h1FFFFF) ? 21'h1FFFFF : v[RES_W-1:0];
  endfunction

  // Axis means round half away from zero and clip to the signed field range.
  function automatic logic [RES_W-1:0] axis_mean(longint sum, longint unsigned den);
    longint unsigned q;
    longint r;
    q = round_div((sum < 0 ? -sum : sum) << 16, den);
    if (sum < 0) r = (q > 1048576) ? -1048576 : -longint'(q);
    else r = (q > 1048575) ? 1048575 : longint'(q);
    return r[RES_W-1:0];
  endfunction

  task automatic absorb_sample(logic [IN_TDATA_W-1:0] data, logic last);
    longint x, y, z;
    longint unsigned sq, sens, len, den, qsum, var_v, sd;
    logic [MAG_W-1:0] mag;
    logic [KIND_W-1:0] kind;
    window_stats_t res;
    x = longint'($signed(data[15:0]));
    y = longint'($signed(data[31:16]));
    z = longint'($signed(data[47:32]));
    len = (len_reg == 0) ? 1 : (len_reg > MAX_WINDOW_DEF ? MAX_WINDOW_DEF : len_reg);
    sens = (sens_reg == 0) ? 1 : sens_reg;
    sq = x * x + y * y + z * z;
    mag = MAG_W'(int_sqrt(sq << 16));
    if (fill < MAX_WINDOW_DEF) mag_mem[fill] = mag;
    fill++;
    acc_x += x;
    acc_y += y;
    acc_z += z;
    acc_mag += mag;
    if (fill >= len) kind = KIND_FULL;
    else if (last) kind = (fill < (len >> 2)) ? KIND_DISCARD : KIND_PARTIAL;
    else return;
    res.wnum = wcount[WNUM_W-1:0];
    res.kind = kind;
    res.mx = '0; res.my = '0; res.mz = '0; res.mmag = '0; res.smag = '0;
    if (kind != KIND_DISCARD) begin
      den = fill * sens;
      res.mx = axis_mean(acc_x, den);
      res.my = axis_mean(acc_y, den);
      res.mz = axis_mean(acc_z, den);
      res.mmag = sat_unsigned(round_div(acc_mag << 8, den));
      if (fill > 1) begin
        qsum = 0;
        for (int i = 0; i < fill && i < MAX_WINDOW_DEF; i++)
          qsum += longint'(mag_mem[i]) * longint'(mag_mem[i]);
        var_v = (fill * qsum - acc_mag * acc_mag) / (fill * (fill - 1));
        sd = int_sqrt(var_v);
        res.smag = sat_unsigned(round_div(sd << 8, sens));
      end
    end
    stats_q.push_back(res);
    if (wcount < 255) wcount++;
    if (last) wcount = 0;
    fill = 0;
    acc_x = 0; acc_y = 0; acc_z = 0; acc_mag = 0;
  endtask

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("checker: %s mismatch, got %0h expected %0h", field, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    checked_o = 0;
  end

  always @(posedge clk_i) begin
    window_stats_t want;
    if (!rst_ni) begin
      sens_reg = SENS_RESET;
      len_reg = LEN_RESET;
      acc_x = 0; acc_y = 0; acc_z = 0; acc_mag = 0;
      fill = 0;
      wcount = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SENS) sens_reg = cfg_wdata_i[SENS_W-1:0];
        else if (cfg_index_i == CFG_LEN) len_reg = cfg_wdata_i[LEN_CFG_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) absorb_sample(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (stats_q.size() == 0) begin
          report("result count", 1, 0);
        end else begin
          want = stats_q.pop_front();
          checked_o++;
          if (m_axis_tdata[7:0] != want.wnum) report("window_number", m_axis_tdata[7:0], want.wnum);
          if (m_axis_tdata[28:8] != want.mx) report("mean_x_g", m_axis_tdata[28:8], want.mx);
          if (m_axis_tdata[49:29] != want.my) report("mean_y_g", m_axis_tdata[49:29], want.my);
          if (m_axis_tdata[70:50] != want.mz) report("mean_z_g", m_axis_tdata[70:50], want.mz);
          if (m_axis_tdata[91:71] != want.mmag)
            report("mean_magnitude_g", m_axis_tdata[91:71], want.mmag);
          if (m_axis_tdata[112:92] != want.smag)
            report("std_magnitude_g", m_axis_tdata[112:92], want.smag);
          if (m_axis_tuser != want.kind) report("window_kind", m_axis_tuser, want.kind);
        end
      end
    end
  end

endmodule

>>> sim/tb_top.sv
// Testbench top that drives samples and configuration and reports the verdict.
module tb_top;
  import aws_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = CFG_SENS;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]      m_axis_tuser;

  int errors, pending, checked;
  int samples_sent = 0;
  // While quiet is set neither side draws a random gap or stall.
  bit quiet = 1'b0;

  // The settle wait is long enough to cover a full window close.
  localparam int SettleCycles = 700;

  always #5 clk_i = ~clk_i;

  accel_window_statistics_top DUT (.*);

  window_stats_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  // The result side draws a fresh stall after every accepted result.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) stall = quiet ? 0 : $urandom_range(0, 6);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Configuration is only changed once the block has drained and settled.
  task automatic settle_and_write(logic [CFG_IDX_W-1:0] idx, int value);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One sample request, preceded by a random gap, held until accepted and then withdrawn.
  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Axis values lean toward the extremes so that the saturation paths are hit.
  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int sens, int len, int count, int last_odds);
    settle_and_write(CFG_SENS, sens);
    settle_and_write(CFG_LEN, len);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_sample(pick_axis(), pick_axis(), pick_axis(),
                  last_odds > 0 && $urandom_range(0, last_odds) == 0);
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A window of four filled with the axis extremes, ending on a
    // burst end so that a full window closes on the last sample of the burst.
    settle_and_write(CFG_SENS, 2048);
    settle_and_write(CFG_LEN, 4);
    send_sample(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'h7FFF, 16'h8000, 16'h0001, 1'b1);
    // A kept partial window of two samples.
    send_sample(16'hFFFF, 16'h0100, 16'h1000, 1'b0);
    send_sample(16'h1000, 16'hF000, 16'h5555, 1'b1);
    // A discarded partial: one sample against a quarter length of two.
    settle_and_write(CFG_LEN, 8);
    send_sample(16'h1234, 16'hAAAA, 16'h4000, 1'b1);
    // A shrunk length: five samples wait, then the length drops to three and
    // the next sample closes a full window of six.
    for (int i = 0; i < 5; i++) send_sample(pick_axis(), pick_axis(), pick_axis(), 1'b0);
    settle_and_write(CFG_LEN, 3);
    send_sample(16'h0800, 16'h0800, 16'h0800, 1'b0);
    // A zero length behaves as one, so each sample is its own window with no spread.
    settle_and_write(CFG_SENS, 0);
    settle_and_write(CFG_LEN, 0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_sample(16'h8000, 16'h0000, 16'h7FFF, 1'b1);

    // Random part across several settings, extremes of both registers among them.
    random_phase(0, 5, 60, 12);
    random_phase(1, 64, 90, 200);
    random_phase(32767, 127, 70, 150);
    // The sender holds off until every expected result has arrived.
    while (pending != 0) @(negedge clk_i);
    random_phase(16384, 16, 70, 25);
    // A long run of single-sample windows with no burst end drives the window
    // number into saturation.
    random_phase(2048, 1, 280, 0);
    random_phase(4096, 0, 40, 4);
    random_phase(3000, 7, 125, 10);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    $display("tb_top: %0d samples sent over directed and seven random settings, %0d windows checked",
             samples_sent, checked);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

>>> files.f
sv/aws_pkg.sv
sv/aws_div.sv
sv/aws_sqrt.sv
sv/aws_dpath.sv
sv/aws_ctrl.sv
sv/accel_window_statistics_top.sv
sim/window_stats_checker.sv
sim/tb_top.sv
